>>> hw/rtl/pls_pkg.sv
package pls_pkg;

   localparam int MAX_POINTS_DEF = 65536;
   localparam int COORD_W        = 32;
   localparam int COUNT_IN_W     = 17;
   localparam int BOXES_W        = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BOXES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_Z     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_M     = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      coord_type m;
   } point_type;

   // what the back end does with one point
   typedef struct packed {
      logic init;
      logic merge;
      logic emit;
      logic last;
      logic use_z;
      logic use_m;
   } op_type;

   typedef struct packed {
      op_type    op;
      point_type pt;
   } entry_type;

   typedef struct packed {
      coord_type x_low;
      coord_type x_high;
      coord_type y_low;
      coord_type y_high;
      coord_type z_low;
      coord_type z_high;
      coord_type m_low;
      coord_type m_high;
   } box_type;

   typedef enum logic {
      FRONT_RUN,
      FRONT_DIVIDE
   } front_state_type;

endpackage

>>> hw/rtl/pls_if.sv
interface pls_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pls_pkg::COORD_W-1:0]    x_coord;
   logic signed [pls_pkg::COORD_W-1:0]    y_coord;
   logic signed [pls_pkg::COORD_W-1:0]    z_coord;
   logic signed [pls_pkg::COORD_W-1:0]    m_coord;
   logic        [pls_pkg::COUNT_IN_W-1:0] num_points;

   modport source (output valid, x_coord, y_coord, z_coord, m_coord, num_points,
                   input ready);
   modport sink (input valid, x_coord, y_coord, z_coord, m_coord, num_points,
                 output ready);
endinterface

interface pls_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pls_pkg::COORD_W-1:0] x_low;
   logic signed [pls_pkg::COORD_W-1:0] x_high;
   logic signed [pls_pkg::COORD_W-1:0] y_low;
   logic signed [pls_pkg::COORD_W-1:0] y_high;
   logic signed [pls_pkg::COORD_W-1:0] z_low;
   logic signed [pls_pkg::COORD_W-1:0] z_high;
   logic signed [pls_pkg::COORD_W-1:0] m_low;
   logic signed [pls_pkg::COORD_W-1:0] m_high;
   logic                               last_box;

   modport source (output valid, x_low, x_high, y_low, y_high, z_low, z_high,
                   m_low, m_high, last_box, input ready);
   modport sink (input valid, x_low, x_high, y_low, y_high, z_low, z_high,
                 m_low, m_high, last_box, output ready);
endinterface

>>> hw/rtl/pls_queue.sv
module pls_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pls_pkg::entry_type  wr_entry,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output pls_pkg::entry_type  head
);

   pls_pkg::entry_type mem_ff [pls_pkg::QUEUE_DEPTH];

   logic [pls_pkg::QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pls_pkg::QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pls_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == pls_pkg::QUEUE_CNT_W'(pls_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

>>> hw/rtl/pls_front.sv
module pls_front #(
   parameter int MaxPoints = pls_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   pls_req_if.sink                       req_ch,
   input  logic [pls_pkg::BOXES_W-1:0]   max_boxes,
   input  logic                          use_z,
   input  logic                          use_m,
   input  logic                          q_full,
   output logic                          q_push,
   output pls_pkg::entry_type            q_entry
);

   localparam int LineW = $clog2(MaxPoints + 1);
   localparam int CntW  = $clog2(LineW + 1);
   localparam int BW    = pls_pkg::BOXES_W;

   pls_pkg::front_state_type state_ff, state_in;

   logic [LineW-1:0] pidx_ff, pidx_in;
   logic [LineW-1:0] len_ff, len_in;
   logic [LineW-1:0] size_ff, size_in;
   logic [BW-1:0]    extra_ff, extra_in;
   logic [BW-1:0]    boxi_ff, boxi_in;
   logic [LineW:0]   gend_ff, gend_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [BW-1:0]    den_ff, den_in;
   logic [LineW-1:0] dq_ff, dq_in;
   logic [BW-1:0]    rem_ff, rem_in;

   logic             accept;
   logic             run_ready;
   logic [LineW-1:0] len_new;
   logic [LineW-1:0] nsegs_new;
   logic             need_div;
   logic             last_pt;
   logic             on_end;
   logic [BW-1:0]    box_next;
   logic [LineW:0]   gend_next;
   logic [BW:0]      rem_sh;
   logic             ge;
   logic [BW-1:0]    rem_step;
   logic [LineW-1:0] quot_step;

   assign run_ready    = (state_ff == pls_pkg::FRONT_RUN) && !q_full;
   assign req_ch.ready = run_ready;
   assign accept       = req_ch.valid && run_ready;

   // count of a new line, clamped to the legal range
   always_comb begin
      if (req_ch.num_points == '0) begin
         len_new = LineW'(1);
      end else if (32'(req_ch.num_points) > 32'(MaxPoints)) begin
         len_new = LineW'(MaxPoints);
      end else begin
         len_new = LineW'(req_ch.num_points);
      end
   end

   assign nsegs_new = len_new - LineW'(1);
   assign need_div  = (max_boxes != '0) && (32'(nsegs_new) > 32'(max_boxes));
   assign last_pt   = (pidx_ff >= len_ff - LineW'(1));
   assign on_end    = ({1'b0, pidx_ff} == gend_ff);
   assign box_next  = boxi_ff + BW'(1);
   assign gend_next = (LineW+1)'(pidx_ff) + (LineW+1)'(size_ff)
                    + (LineW+1)'(box_next < extra_ff);

   // one restoring divide step per cycle
   assign rem_sh    = {rem_ff, dq_ff[LineW-1]};
   assign ge        = (rem_sh >= {1'b0, den_ff});
   assign rem_step  = ge ? BW'(rem_sh - {1'b0, den_ff}) : rem_sh[BW-1:0];
   assign quot_step = {dq_ff[LineW-2:0], ge};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pls_pkg::FRONT_RUN: begin
            if (accept && (pidx_ff == '0) && need_div) begin
               state_in = pls_pkg::FRONT_DIVIDE;
            end
         end
         pls_pkg::FRONT_DIVIDE: begin
            if (cnt_ff == CntW'(1)) begin
               state_in = pls_pkg::FRONT_RUN;
            end
         end
         default: state_in = pls_pkg::FRONT_RUN;
      endcase
   end

   always_comb begin
      pidx_in  = pidx_ff;
      len_in   = len_ff;
      size_in  = size_ff;
      extra_in = extra_ff;
      boxi_in  = boxi_ff;
      gend_in  = gend_ff;
      cnt_in   = cnt_ff;
      den_in   = den_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;

      q_push         = accept;
      q_entry.pt.x   = req_ch.x_coord;
      q_entry.pt.y   = req_ch.y_coord;
      q_entry.pt.z   = req_ch.z_coord;
      q_entry.pt.m   = req_ch.m_coord;
      q_entry.op     = '0;
      q_entry.op.use_z = use_z;
      q_entry.op.use_m = use_m;

      case (state_ff)
         pls_pkg::FRONT_RUN: begin
            if (accept) begin
               if (pidx_ff == '0) begin
                  len_in          = len_new;
                  boxi_in         = '0;
                  q_entry.op.init = 1'b1;
                  if (len_new == LineW'(1)) begin
                     q_entry.op.emit = 1'b1;
                     q_entry.op.last = 1'b1;
                  end else begin
                     pidx_in = LineW'(1);
                     if (need_div) begin
                        den_in = max_boxes;
                        dq_in  = nsegs_new;
                        rem_in = '0;
                        cnt_in = CntW'(LineW);
                     end else begin
                        size_in  = LineW'(1);
                        extra_in = '0;
                        gend_in  = (LineW+1)'(1);
                     end
                  end
               end else begin
                  q_entry.op.merge = 1'b1;
                  if (last_pt) begin
                     q_entry.op.emit = 1'b1;
                     q_entry.op.last = 1'b1;
                     pidx_in         = '0;
                  end else begin
                     pidx_in = pidx_ff + LineW'(1);
                     if (on_end) begin
                        q_entry.op.emit = 1'b1;
                        q_entry.op.init = 1'b1;
                        boxi_in         = box_next;
                        gend_in         = gend_next;
                     end
                  end
               end
            end
         end
         pls_pkg::FRONT_DIVIDE: begin
            rem_in = rem_step;
            dq_in  = quot_step;
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               size_in  = quot_step;
               extra_in = rem_step;
               gend_in  = (LineW+1)'(quot_step)
                        + (LineW+1)'(rem_step != '0);
            end
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pls_pkg::FRONT_RUN;
         pidx_ff  <= '0;
         len_ff   <= '0;
         size_ff  <= '0;
         extra_ff <= '0;
         boxi_ff  <= '0;
         gend_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pidx_ff  <= pidx_in;
         len_ff   <= len_in;
         size_ff  <= size_in;
         extra_ff <= extra_in;
         boxi_ff  <= boxi_in;
         gend_ff  <= gend_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

endmodule

>>> hw/rtl/pls_back.sv
module pls_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  pls_pkg::entry_type q_head,
   output logic               q_pop,
   pls_rsp_if.source          rsp_ch
);

   pls_pkg::box_type box_ff, box_in;
   pls_pkg::box_type out_ff, out_in;
   logic             last_ff, last_in;
   logic             valid_ff, valid_in;

   pls_pkg::box_type init_box;
   pls_pkg::box_type merged;
   pls_pkg::box_type emit_box;
   logic             can_emit;

   assign can_emit = !valid_ff || rsp_ch.ready;
   assign q_pop    = q_valid && (!q_head.op.emit || can_emit);

   always_comb begin
      init_box.x_low  = q_head.pt.x;
      init_box.x_high = q_head.pt.x;
      init_box.y_low  = q_head.pt.y;
      init_box.y_high = q_head.pt.y;
      init_box.z_low  = q_head.op.use_z ? q_head.pt.z : '0;
      init_box.z_high = q_head.op.use_z ? q_head.pt.z : '0;
      init_box.m_low  = q_head.op.use_m ? q_head.pt.m : '0;
      init_box.m_high = q_head.op.use_m ? q_head.pt.m : '0;
   end

   always_comb begin
      merged = box_ff;
      if ($signed(q_head.pt.x) < $signed(box_ff.x_low)) begin
         merged.x_low = q_head.pt.x;
      end
      if ($signed(q_head.pt.x) > $signed(box_ff.x_high)) begin
         merged.x_high = q_head.pt.x;
      end
      if ($signed(q_head.pt.y) < $signed(box_ff.y_low)) begin
         merged.y_low = q_head.pt.y;
      end
      if ($signed(q_head.pt.y) > $signed(box_ff.y_high)) begin
         merged.y_high = q_head.pt.y;
      end
      if (q_head.op.use_z) begin
         if ($signed(q_head.pt.z) < $signed(box_ff.z_low)) begin
            merged.z_low = q_head.pt.z;
         end
         if ($signed(q_head.pt.z) > $signed(box_ff.z_high)) begin
            merged.z_high = q_head.pt.z;
         end
      end
      if (q_head.op.use_m) begin
         if ($signed(q_head.pt.m) < $signed(box_ff.m_low)) begin
            merged.m_low = q_head.pt.m;
         end
         if ($signed(q_head.pt.m) > $signed(box_ff.m_high)) begin
            merged.m_high = q_head.pt.m;
         end
      end
   end

   // a closing point is merged before the box goes out, a new box starts after
   always_comb begin
      emit_box = q_head.op.merge ? merged : init_box;
      if (!q_head.op.use_z) begin
         emit_box.z_low  = '0;
         emit_box.z_high = '0;
      end
      if (!q_head.op.use_m) begin
         emit_box.m_low  = '0;
         emit_box.m_high = '0;
      end
   end

   always_comb begin
      box_in   = box_ff;
      out_in   = out_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ch.ready;
      if (q_pop) begin
         box_in = q_head.op.init ? init_box : merged;
         if (q_head.op.emit) begin
            out_in   = emit_box;
            last_in  = q_head.op.last;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      box_ff  <= box_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.x_low    = out_ff.x_low;
   assign rsp_ch.x_high   = out_ff.x_high;
   assign rsp_ch.y_low    = out_ff.y_low;
   assign rsp_ch.y_high   = out_ff.y_high;
   assign rsp_ch.z_low    = out_ff.z_low;
   assign rsp_ch.z_high   = out_ff.z_high;
   assign rsp_ch.m_low    = out_ff.m_low;
   assign rsp_ch.m_high   = out_ff.m_high;
   assign rsp_ch.last_box = last_ff;

endmodule

>>> hw/rtl/polyline_segment_boxes.sv
// channel   | dir | handshake        | beat
// ----------+-----+------------------+------------------------------------------
// req_ch    | in  | valid/ready      | one point: x, y, z, m, num_points
// rsp_ch    | out | valid/ready      | one box: x/y/z/m low and high, last_box
// csr_*     | in  | csr_we, no wait  | max_boxes (0), use_z (1), use_m (2)
//
// one point a cycle sustained while rsp_ch is ready and no divide is running; a box
// reaches rsp_ch by way of a four-entry queue and an output register
// after the first point of a line that needs grouping is taken, req_ch is held
// while the group size and remainder are divided out bit by bit
// a stalled rsp_ch backs up into the queue, then into req_ch.ready
// reset is synchronous and clears the counters, the queue and the output valid
module polyline_segment_boxes #(
   parameter int MaxPoints = pls_pkg::MAX_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   pls_req_if.sink                            req_ch,
   pls_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [pls_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pls_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [pls_pkg::BOXES_W-1:0] max_boxes_ff;
   logic                        use_z_ff;
   logic                        use_m_ff;

   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_valid;
   pls_pkg::entry_type q_wr_entry;
   pls_pkg::entry_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_boxes_ff <= '0;
         use_z_ff     <= 1'b0;
         use_m_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            pls_pkg::CSR_MAX_BOXES: max_boxes_ff <= csr_data[pls_pkg::BOXES_W-1:0];
            pls_pkg::CSR_USE_Z:     use_z_ff     <= csr_data[0];
            pls_pkg::CSR_USE_M:     use_m_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   pls_front #(
      .MaxPoints (MaxPoints)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .max_boxes (max_boxes_ff),
      .use_z     (use_z_ff),
      .use_m     (use_m_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_wr_entry)
   );

   pls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .wr_entry   (q_wr_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head)
   );

   pls_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
